### hw/rtl/mshe_pkg.sv
// mshe_pkg: shared constants, codes and fixed-point helpers of the
// marker scale height estimator; used by the top level
package mshe_pkg;

	localparam int POLY_TERMS_DEF = 4;
	localparam int NUM_POLYS      = 4;

	// register indexes
	localparam logic [2:0] REG_MODE     = 3'd0;
	localparam logic [2:0] REG_K_FACTOR = 3'd1;
	localparam logic [2:0] REG_SLOPE    = 3'd2;
	localparam logic [2:0] REG_OFFSET   = 3'd3;
	localparam logic [2:0] REG_REF_AREA = 3'd4;
	localparam logic [2:0] REG_FOCAL    = 3'd5;
	localparam logic [2:0] REG_ANA_A    = 3'd6;
	localparam logic [2:0] REG_ANA_B    = 3'd7;

	// modes
	localparam logic [2:0] MODE_KFACTOR   = 3'd0;
	localparam logic [2:0] MODE_TWOPOINT  = 3'd1;
	localparam logic [2:0] MODE_ZGRID     = 3'd2;
	localparam logic [2:0] MODE_BBOX      = 3'd3;
	localparam logic [2:0] MODE_GEOMETRIC = 3'd4;
	localparam logic [2:0] MODE_BILATERAL = 3'd5;
	localparam logic [2:0] MODE_ANALYTIC  = 3'd6;
	localparam logic [2:0] MODE_UNUSED    = 3'd7;

	// polynomial selects
	localparam int POLY_K     = 0;
	localparam int POLY_GEOM  = 1;
	localparam int POLY_SLOPE = 2;
	localparam int POLY_OFFS  = 3;

	// status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_GUARD = 2'd1;
	localparam logic [1:0] ST_NEG   = 2'd2;
	localparam logic [1:0] ST_SAT   = 2'd3;

	localparam logic signed [63:0] S32_MAX    = 64'sh0000_0000_7fff_ffff;
	localparam logic signed [63:0] S32_MIN    = 64'shffff_ffff_8000_0000;
	localparam logic signed [63:0] DENOM_TINY = 64'sd6;
	localparam logic signed [31:0] Q_ONE      = 32'sh0001_0000;

	typedef struct packed {
		logic [30:0] height;
		logic [1:0]  status;
	} res_t;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		if (v > S32_MAX) return S32_MAX[31:0];
		else if (v < S32_MIN) return S32_MIN[31:0];
		else return v[31:0];
	endfunction

	function automatic logic signed [63:0] sext32(input logic signed [31:0] v);
		return {{32{v[31]}}, v};
	endfunction

	function automatic res_t finish(input logic signed [63:0] h);
		res_t r;
		if (h < 0) begin
			r.height = '0;
			r.status = ST_NEG;
		end else if (h > S32_MAX) begin
			r.height = 31'h7fff_ffff;
			r.status = ST_SAT;
		end else begin
			r.height = h[30:0];
			r.status = ST_OK;
		end
		return r;
	endfunction

endpackage

### hw/rtl/marker_scale_height_estimator_core.sv
// marker_scale_height_estimator_core: top level, config registers,
// coefficient store and sequencer; uses mshe_pkg and mshe_div
//
//  channel  | direction | handshake           | payload
//  cfg      | in        | cfg_valid/cfg_ready | cfg_index, cfg_data
//  in       | in        | in_valid/in_stall   | action .. term_value
//  out      | out       | out_valid/out_stall | height, status
//
// a load item is written from the idle state; a compute item ends early when a guard trips
// before any division, and otherwise runs through at most two divisions on the
// one-bit-per-cycle divider, the multiplies and the horner terms
// reset clears config registers and the coefficient store valid bits at once
// in_stall is high while an item is in work; the result waits in the output
// register, and the next item is taken once the result has moved into it
module marker_scale_height_estimator_core #(
	parameter int POLY_TERMS = mshe_pkg::POLY_TERMS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               action,
	input  logic signed [31:0] rim_size,
	input  logic signed [31:0] tray_size,
	input  logic signed [31:0] tray_distance,
	input  logic [11:0]        box_left,
	input  logic [11:0]        box_top,
	input  logic [11:0]        box_right,
	input  logic [11:0]        box_bottom,
	input  logic [1:0]         poly_select,
	input  logic [1:0]         term_index,
	input  logic signed [31:0] term_value,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [30:0]        height,
	output logic [1:0]         status
);
	localparam int DEPTH = mshe_pkg::NUM_POLYS * POLY_TERMS;
	localparam int AW    = $clog2(DEPTH);
	localparam int IW    = $clog2(POLY_TERMS + 1);

	typedef enum logic [4:0] {
		S_IDLE, S_DISP, S_MWAIT, S_DWAIT, S_HMUL, S_HWAIT, S_HADD,
		S_RCHK, S_DIVT, S_ADDT, S_M2H, S_M3AREA, S_M3SC, S_M3M,
		S_M5H2, S_M5H3, S_M5T, S_GDIV, S_GH, S_GT, S_FINAL, S_FINP,
		S_M6NUM, S_M6FIN, S_GUARD, S_OUTW
	} state_t;

	state_t state_q, ret_q, hret_q;

	// config registers
	logic [2:0]         mode_q;
	logic signed [31:0] k_q, slope_q, offset_q, ana_a_q, ana_b_q;
	logic [24:0]        ref_area_q;
	logic [30:0]        focal_q;

	// item registers
	logic signed [31:0] rim_q, tray_q, z_q;
	logic signed [12:0] bh_q, bw_q;

	// working registers
	logic signed [31:0] ratio_q, t_q, r_q, h2_q;
	logic signed [31:0] mul_a_q, mul_b_q;
	logic signed [63:0] prod_q;
	logic [AW-1:0]      hbase_q, raddr_q;
	logic [IW-1:0]      i_q;
	mshe_pkg::res_t     res_q, out_q;
	logic               out_valid_q;

	// divider
	logic               div_start_q, div_done;
	logic signed [63:0] div_a_q, div_b_q, quo;

	// coefficient store
	logic signed [31:0] mem [DEPTH];
	logic [DEPTH-1:0]   mem_vld_q;
	logic signed [31:0] coef_q;
	logic               accept, load_we;
	logic [AW-1:0]      waddr;

	logic signed [31:0] m_c, qs_c;
	logic signed [63:0] denom_c, area_c, num_c;
	logic signed [12:0] bhc_c;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != S_IDLE);
	assign accept    = in_valid && !in_stall;
	assign load_we   = accept && action && (int'(term_index) < POLY_TERMS);
	assign waddr     = AW'(int'(poly_select) * POLY_TERMS + int'(term_index));

	assign m_c     = mshe_pkg::sat32(prod_q >>> 16);
	assign qs_c    = mshe_pkg::sat32(quo);
	assign denom_c = {{35{bh_q[12]}}, bh_q, 16'b0} + mshe_pkg::sext32(ana_b_q);
	assign area_c  = (prod_q < 64'sd1) ? 64'sd1 : prod_q;
	assign num_c   = prod_q - mshe_pkg::sext32(ana_a_q);
	assign bhc_c   = (bh_q < 13'sd1) ? 13'sd1 : bh_q;

	mshe_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start_q),
		.dividend (div_a_q),
		.divisor  (div_b_q),
		.done     (div_done),
		.quotient (quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= '0;
			k_q        <= '0;
			slope_q    <= '0;
			offset_q   <= '0;
			ref_area_q <= '0;
			focal_q    <= '0;
			ana_a_q    <= '0;
			ana_b_q    <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				mshe_pkg::REG_MODE:     mode_q     <= cfg_data[2:0];
				mshe_pkg::REG_K_FACTOR: k_q        <= cfg_data;
				mshe_pkg::REG_SLOPE:    slope_q    <= cfg_data;
				mshe_pkg::REG_OFFSET:   offset_q   <= cfg_data;
				mshe_pkg::REG_REF_AREA: ref_area_q <= cfg_data[24:0];
				mshe_pkg::REG_FOCAL:    focal_q    <= cfg_data[30:0];
				mshe_pkg::REG_ANA_A:    ana_a_q    <= cfg_data;
				mshe_pkg::REG_ANA_B:    ana_b_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) mem_vld_q <= '0;
		else if (load_we) mem_vld_q[waddr] <= 1'b1;
	end

	always_ff @(posedge clk) begin
		if (load_we) mem[waddr] <= term_value;
	end

	// unwritten entries read as zero
	always_ff @(posedge clk) begin
		coef_q <= mem_vld_q[raddr_q] ? mem[raddr_q] : 32'sd0;
	end

	// shared multiplier, operands registered, product registered
	always_ff @(posedge clk) begin
		prod_q <= 64'(mul_a_q * mul_b_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ret_q       <= S_IDLE;
			hret_q      <= S_IDLE;
			out_valid_q <= 1'b0;
			div_start_q <= 1'b0;
			i_q         <= '0;
		end else begin
			div_start_q <= 1'b0;
			if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept && !action) begin
						rim_q   <= rim_size;
						tray_q  <= tray_size;
						z_q     <= tray_distance;
						bh_q    <= $signed({1'b0, box_bottom}) - $signed({1'b0, box_top});
						bw_q    <= $signed({1'b0, box_right}) - $signed({1'b0, box_left});
						state_q <= S_DISP;
					end
				end
				S_DISP: begin
					if (mode_q == mshe_pkg::MODE_UNUSED) begin
						state_q <= S_GUARD;
					end else if (mode_q == mshe_pkg::MODE_GEOMETRIC) begin
						if (z_q <= 0 || focal_q == '0) state_q <= S_GUARD;
						else begin
							div_a_q     <= {{19{bhc_c[12]}}, bhc_c, 32'b0};
							div_b_q     <= {33'b0, focal_q};
							div_start_q <= 1'b1;
							ret_q       <= S_GDIV;
							state_q     <= S_DWAIT;
						end
					end else if (mode_q == mshe_pkg::MODE_ANALYTIC) begin
						if (z_q <= 0 || (denom_c >= -mshe_pkg::DENOM_TINY
							&& denom_c <= mshe_pkg::DENOM_TINY)) state_q <= S_GUARD;
						else begin
							mul_a_q <= 32'(bh_q);
							mul_b_q <= z_q;
							ret_q   <= S_M6NUM;
							state_q <= S_MWAIT;
						end
					end else begin
						if (tray_q <= 0 || z_q <= 0) state_q <= S_GUARD;
						else begin
							div_a_q     <= {{16{rim_q[31]}}, rim_q, 16'b0};
							div_b_q     <= mshe_pkg::sext32(tray_q);
							div_start_q <= 1'b1;
							ret_q       <= S_RCHK;
							state_q     <= S_DWAIT;
						end
					end
				end
				S_MWAIT: state_q <= ret_q;
				S_DWAIT: if (div_done) state_q <= ret_q;
				// horner: r = sat(floor(r*z) + c), one term per pass
				S_HMUL: begin
					mul_a_q <= r_q;
					mul_b_q <= z_q;
					raddr_q <= hbase_q + AW'(i_q);
					state_q <= S_HWAIT;
				end
				S_HWAIT: state_q <= S_HADD;
				S_HADD: begin
					r_q <= mshe_pkg::sat32(mshe_pkg::sext32(m_c) + mshe_pkg::sext32(coef_q));
					if (i_q == IW'(POLY_TERMS - 1)) state_q <= hret_q;
					else begin
						i_q     <= i_q + IW'(1);
						state_q <= S_HMUL;
					end
				end
				S_RCHK: begin
					ratio_q <= qs_c;
					if (qs_c <= 0) state_q <= S_GUARD;
					else begin
						case (mode_q)
							mshe_pkg::MODE_KFACTOR: begin
								div_a_q     <= {{16{k_q[31]}}, k_q, 16'b0};
								div_b_q     <= mshe_pkg::sext32(qs_c);
								div_start_q <= 1'b1;
								ret_q       <= S_DIVT;
								state_q     <= S_DWAIT;
							end
							mshe_pkg::MODE_TWOPOINT: begin
								mul_a_q <= slope_q;
								mul_b_q <= qs_c;
								ret_q   <= S_ADDT;
								state_q <= S_MWAIT;
							end
							mshe_pkg::MODE_ZGRID: begin
								r_q     <= '0;
								i_q     <= '0;
								hbase_q <= AW'(mshe_pkg::POLY_K * POLY_TERMS);
								hret_q  <= S_M2H;
								state_q <= S_HMUL;
							end
							mshe_pkg::MODE_BBOX: begin
								mul_a_q <= 32'(bw_q);
								mul_b_q <= 32'(bh_q);
								ret_q   <= S_M3AREA;
								state_q <= S_MWAIT;
							end
							default: begin
								r_q     <= '0;
								i_q     <= '0;
								hbase_q <= AW'(mshe_pkg::POLY_SLOPE * POLY_TERMS);
								hret_q  <= S_M5H2;
								state_q <= S_HMUL;
							end
						endcase
					end
				end
				S_DIVT: begin
					t_q     <= mshe_pkg::sat32(mshe_pkg::sext32(mshe_pkg::Q_ONE)
						- mshe_pkg::sext32(qs_c));
					state_q <= S_FINAL;
				end
				S_ADDT: begin
					t_q     <= mshe_pkg::sat32(mshe_pkg::sext32(m_c)
						+ mshe_pkg::sext32(offset_q));
					state_q <= S_FINAL;
				end
				S_M2H: begin
					div_a_q     <= {{16{r_q[31]}}, r_q, 16'b0};
					div_b_q     <= mshe_pkg::sext32(ratio_q);
					div_start_q <= 1'b1;
					ret_q       <= S_DIVT;
					state_q     <= S_DWAIT;
				end
				S_M3AREA: begin
					div_a_q     <= {23'b0, ref_area_q, 16'b0};
					div_b_q     <= area_c;
					div_start_q <= 1'b1;
					ret_q       <= S_M3SC;
					state_q     <= S_DWAIT;
				end
				S_M3SC: begin
					mul_a_q <= slope_q;
					mul_b_q <= qs_c;
					ret_q   <= S_M3M;
					state_q <= S_MWAIT;
				end
				S_M3M: begin
					mul_a_q <= m_c;
					mul_b_q <= ratio_q;
					ret_q   <= S_ADDT;
					state_q <= S_MWAIT;
				end
				S_M5H2: begin
					h2_q    <= r_q;
					r_q     <= '0;
					i_q     <= '0;
					hbase_q <= AW'(mshe_pkg::POLY_OFFS * POLY_TERMS);
					hret_q  <= S_M5H3;
					state_q <= S_HMUL;
				end
				S_M5H3: begin
					mul_a_q <= h2_q;
					mul_b_q <= ratio_q;
					ret_q   <= S_M5T;
					state_q <= S_MWAIT;
				end
				S_M5T: begin
					t_q     <= mshe_pkg::sat32(mshe_pkg::sext32(m_c) + mshe_pkg::sext32(r_q));
					state_q <= S_FINAL;
				end
				S_GDIV: begin
					t_q     <= qs_c;
					r_q     <= '0;
					i_q     <= '0;
					hbase_q <= AW'(mshe_pkg::POLY_GEOM * POLY_TERMS);
					hret_q  <= S_GH;
					state_q <= S_HMUL;
				end
				S_GH: begin
					mul_a_q <= t_q;
					mul_b_q <= r_q;
					ret_q   <= S_GT;
					state_q <= S_MWAIT;
				end
				S_GT: begin
					t_q     <= m_c;
					state_q <= S_FINAL;
				end
				S_FINAL: begin
					mul_a_q <= z_q;
					mul_b_q <= t_q;
					ret_q   <= S_FINP;
					state_q <= S_MWAIT;
				end
				S_FINP: begin
					res_q   <= mshe_pkg::finish(prod_q >>> 16);
					state_q <= S_OUTW;
				end
				S_M6NUM: begin
					div_a_q     <= {num_c[47:0], 16'b0};
					div_b_q     <= denom_c;
					div_start_q <= 1'b1;
					ret_q       <= S_M6FIN;
					state_q     <= S_DWAIT;
				end
				S_M6FIN: begin
					res_q   <= mshe_pkg::finish(quo);
					state_q <= S_OUTW;
				end
				S_GUARD: begin
					res_q.height <= '0;
					res_q.status <= mshe_pkg::ST_GUARD;
					state_q      <= S_OUTW;
				end
				S_OUTW: begin
					if (!out_valid_q || !out_stall) begin
						out_q       <= res_q;
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign height    = out_q.height;
	assign status    = out_q.status;

	a_div_done_waits: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == S_DWAIT))
		else $error("divider finished outside a wait");

	a_zero_height: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == mshe_pkg::ST_GUARD || status == mshe_pkg::ST_NEG)
		|-> (height == '0))
		else $error("guarded or clamped item with nonzero height");

	a_sat_height: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == mshe_pkg::ST_SAT) |-> (height == 31'h7fff_ffff))
		else $error("saturated item without full-scale height");

	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		load_we |-> (state_q == S_IDLE) ##1 (state_q == S_IDLE))
		else $error("coefficient load left the idle state");

endmodule

### hw/rtl/mshe_div.sv
// mshe_div: signed 64-bit divider, one quotient bit per cycle, truncating
// toward zero; no package dependencies
module mshe_div (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [63:0] dividend,
	input  logic signed [63:0] divisor,
	output logic               done,
	output logic signed [63:0] quotient
);
	logic        busy_q;
	logic        done_q;
	logic        neg_q;
	logic [5:0]  cnt_q;
	logic [64:0] rem_q;
	logic [63:0] dvd_q;
	logic [63:0] dvs_q;
	logic [64:0] rem_sh;
	logic        fit;

	assign rem_sh = {rem_q[63:0], dvd_q[63]};
	assign fit    = rem_sh >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// magnitudes in, sign fixed up at the output
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend[63] ? 64'(-dividend) : 64'(dividend);
			dvs_q <= divisor[63] ? 64'(-divisor) : 64'(divisor);
			rem_q <= '0;
			neg_q <= dividend[63] ^ divisor[63];
		end else if (busy_q) begin
			rem_q <= fit ? (rem_sh - {1'b0, dvs_q}) : rem_sh;
			dvd_q <= {dvd_q[62:0], fit};
		end
	end

	assign done     = done_q;
	assign quotient = neg_q ? -$signed(dvd_q) : $signed(dvd_q);

endmodule
